// ===== sv/bmst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmst_pkg
// shared types and constants for the binary matrix-vector subset-sum block
// ----------------------------------------------------------------------------
package bmst_pkg;

	// field widths of the words on the ports
	localparam int FIELD_BITS   = 24;
	localparam int ROW_BITS     = 6;
	localparam int PATTERN_BITS = 8;
	localparam int SUM_OUT_BITS = 48;
	localparam int MAX_LANES    = 8;

	// rows reachable through the row field
	localparam int ROW_SPACE = 2 ** ROW_BITS;

	// lanes used in four-column mode
	localparam int GROUP_SMALL = 4;

	// parameter defaults
	localparam int ROWS_DEF       = 64;
	localparam int LANES_DEF      = 8;
	localparam int VALUE_BITS_DEF = 24;
	localparam int ACC_BITS_DEF   = 48;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ACC   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} bmst_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_ACC,
		ST_READ
	} bmst_state_t;

	typedef struct packed {
		bmst_op_t                      op;
		logic [ROW_BITS-1:0]           row;
		logic [PATTERN_BITS-1:0]       pattern;
		logic signed [FIELD_BITS-1:0]  x0;
		logic signed [FIELD_BITS-1:0]  x1;
		logic signed [FIELD_BITS-1:0]  x2;
		logic signed [FIELD_BITS-1:0]  x3;
		logic signed [FIELD_BITS-1:0]  x4;
		logic signed [FIELD_BITS-1:0]  x5;
		logic signed [FIELD_BITS-1:0]  x6;
		logic signed [FIELD_BITS-1:0]  x7;
	} bmst_in_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]             out_row;
		logic signed [SUM_OUT_BITS-1:0]  row_sum;
		logic                            overflowed;
	} bmst_out_t;

	// control from the sequencer to the row accumulator store
	typedef struct packed {
		logic rd_en;
		logic upd_en;
		logic clr;
	} bmst_rowctl_t;

endpackage

// ===== sv/bmst_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmst_lane
// one vector lane: holds a chunk value and gates it by its pattern bit
// ----------------------------------------------------------------------------
module bmst_lane #(
	parameter int VALUE_BITS = bmst_pkg::VALUE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load_en,
	input  logic signed [bmst_pkg::FIELD_BITS-1:0] x_in,
	input  logic                                  acc_en,
	input  logic                                  sel,
	output logic signed [VALUE_BITS-1:0]          masked_s1
);

	localparam int CMP_BITS = (VALUE_BITS > bmst_pkg::FIELD_BITS) ?
		VALUE_BITS : bmst_pkg::FIELD_BITS;
	localparam logic signed [CMP_BITS-1:0] HI =
		{{(CMP_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
	localparam logic signed [CMP_BITS-1:0] LO = ~HI;

	logic signed [CMP_BITS-1:0]   x_wide;
	logic signed [CMP_BITS-1:0]   x_clip;
	logic signed [VALUE_BITS-1:0] x_q;

	// clip the field into the stored value range
	always_comb begin
		x_wide = CMP_BITS'(x_in);
		if (x_wide > HI) begin
			x_clip = HI;
		end else if (x_wide < LO) begin
			x_clip = LO;
		end else begin
			x_clip = x_wide;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
		end else if (load_en) begin
			x_q <= VALUE_BITS'(x_clip);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			masked_s1 <= sel ? x_q : '0;
		end
	end

endmodule

// ===== sv/bmst_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmst_merge
// adds the gated lane values into one subset sum
// ----------------------------------------------------------------------------
module bmst_merge #(
	parameter int LANES      = bmst_pkg::LANES_DEF,
	parameter int VALUE_BITS = bmst_pkg::VALUE_BITS_DEF,
	parameter int SUM_BITS   = VALUE_BITS + $clog2(LANES)
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [VALUE_BITS-1:0] lane_s1 [LANES],
	output logic signed [SUM_BITS-1:0]   sum_s2
);

	logic signed [SUM_BITS-1:0] sum_d;

	always_comb begin
		sum_d = '0;
		for (int k = 0; k < LANES; k++) begin
			sum_d = sum_d + SUM_BITS'(lane_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_d;
		end
	end

endmodule

// ===== sv/bmst_rowacc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmst_rowacc
// per-row accumulator store with sticky flags and saturating update
// ----------------------------------------------------------------------------
module bmst_rowacc #(
	parameter int ROW_DEPTH = bmst_pkg::ROWS_DEF,
	parameter int ADDR_BITS = bmst_pkg::ROW_BITS,
	parameter int ACC_BITS  = bmst_pkg::ACC_BITS_DEF,
	parameter int SUM_BITS  = bmst_pkg::VALUE_BITS_DEF + $clog2(bmst_pkg::LANES_DEF)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bmst_pkg::bmst_rowctl_t     ctl,
	input  logic [ADDR_BITS-1:0]       rd_addr,
	input  logic [ADDR_BITS-1:0]       wr_addr,
	input  logic signed [SUM_BITS-1:0] sum,
	output logic signed [ACC_BITS-1:0] rd_acc,
	output logic                       rd_flag
);

	localparam int WIDE = ((ACC_BITS > SUM_BITS) ? ACC_BITS : SUM_BITS) + 1;
	localparam logic signed [WIDE-1:0] HI =
		{{(WIDE - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
	localparam logic signed [WIDE-1:0] LO = ~HI;

	// word layout: flag above accumulator
	logic [ACC_BITS:0]          mem_q [ROW_DEPTH];
	logic [ROW_DEPTH-1:0]       valid_q;
	logic [ACC_BITS:0]          data_q;
	logic                       live_q;
	logic signed [WIDE-1:0]     total;
	logic signed [ACC_BITS-1:0] new_acc;
	logic                       new_flag;

	// an entry not written since clear reads as zero
	assign rd_acc  = live_q ? $signed(data_q[ACC_BITS-1:0]) : '0;
	assign rd_flag = live_q & data_q[ACC_BITS];

	always_comb begin
		total    = WIDE'(rd_acc) + WIDE'(sum);
		new_flag = rd_flag;
		if (total > HI) begin
			new_acc  = HI[ACC_BITS-1:0];
			new_flag = 1'b1;
		end else if (total < LO) begin
			new_acc  = LO[ACC_BITS-1:0];
			new_flag = 1'b1;
		end else begin
			new_acc = total[ACC_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			data_q <= mem_q[rd_addr];
		end
		if (ctl.upd_en) begin
			mem_q[wr_addr] <= {new_flag, new_acc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				live_q <= valid_q[rd_addr];
			end
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.upd_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	a_no_clr_during_upd : assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.clr && ctl.upd_en))
		else $error("clear and update in the same cycle");

	a_upd_sets_valid : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd_en |=> valid_q[$past(wr_addr)])
		else $error("updated row not marked valid");

	a_clr_empties : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |=> (valid_q == '0))
		else $error("clear left valid rows");

endmodule

// ===== sv/binary_matvec_subset_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_matvec_subset_table
// binary matrix times fixed-point vector, one column group per chunk word
// ----------------------------------------------------------------------------
// load and clear words leave the sequencer idle; the next word is accepted at once
// accumulate words pass lane gating, merge add and row update in that order
// read words wait until the output register is free; the result sits in that register
// the row store's read-modify-write loop holds the sequencer until the row update
// reset clears chunk values, row valid bits and sets eight-column mode
// ----------------------------------------------------------------------------
module binary_matvec_subset_table #(
	parameter int ROWS       = bmst_pkg::ROWS_DEF,
	parameter int LANES      = bmst_pkg::LANES_DEF,
	parameter int VALUE_BITS = bmst_pkg::VALUE_BITS_DEF,
	parameter int ACC_BITS   = bmst_pkg::ACC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  bmst_pkg::bmst_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output bmst_pkg::bmst_out_t result,
	input  logic                cfg_wen,
	input  logic                cfg_wdata
);

	// subset sum of all lanes needs log2(lanes) extra bits
	localparam int SUM_BITS  = VALUE_BITS + $clog2(LANES);
	// rows above the row field's reach can never be addressed
	localparam int ROW_DEPTH = (ROWS < bmst_pkg::ROW_SPACE) ? ROWS : bmst_pkg::ROW_SPACE;
	localparam int ADDR_BITS = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

	bmst_pkg::bmst_state_t  st_q, st_d;
	bmst_pkg::bmst_rowctl_t ctl;
	bmst_pkg::bmst_out_t    result_q;

	logic                                   group_mode_q;
	logic                                   result_valid_q;
	logic                                   accept;
	logic                                   in_range;
	logic                                   out_free;
	logic                                   load_out;
	logic [bmst_pkg::ROW_BITS-1:0]          row_q;
	logic                                   hit_q;
	logic signed [bmst_pkg::FIELD_BITS-1:0] x_field [bmst_pkg::MAX_LANES];
	logic signed [VALUE_BITS-1:0]           lane_s1 [LANES];
	logic signed [SUM_BITS-1:0]             sum_s2;
	logic signed [ACC_BITS-1:0]             rd_acc;
	logic                                   rd_flag;

	assign accept   = item_valid & item_ready;
	assign in_range = int'(item.row) < ROWS;
	assign out_free = !result_valid_q || result_ready;

	assign x_field[0] = item.x0;
	assign x_field[1] = item.x1;
	assign x_field[2] = item.x2;
	assign x_field[3] = item.x3;
	assign x_field[4] = item.x4;
	assign x_field[5] = item.x5;
	assign x_field[6] = item.x6;
	assign x_field[7] = item.x7;

	// group mode register, eight-column groups after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_mode_q <= 1'b1;
		end else if (cfg_wen) begin
			group_mode_q <= cfg_wdata;
		end
	end

	// sequencer: one word in flight at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bmst_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d       = st_q;
		load_out   = 1'b0;
		item_ready = 1'b0;
		case (st_q)
			bmst_pkg::ST_IDLE: begin
				// ready is high here, so a valid word is taken this cycle
				item_ready = 1'b1;
				if (item_valid) begin
					// accumulate on a row beyond the store is dropped
					if (item.op == bmst_pkg::OP_ACC && in_range) begin
						st_d = bmst_pkg::ST_SUM;
					end else if (item.op == bmst_pkg::OP_READ) begin
						st_d = bmst_pkg::ST_READ;
					end
				end
			end
			bmst_pkg::ST_SUM: begin
				st_d = bmst_pkg::ST_ACC;
			end
			bmst_pkg::ST_ACC: begin
				st_d = bmst_pkg::ST_IDLE;
			end
			bmst_pkg::ST_READ: begin
				// wait here only while an earlier result is still unclaimed
				if (out_free) begin
					load_out = 1'b1;
					st_d     = bmst_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = bmst_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.rd_en  = accept && in_range &&
			(item.op == bmst_pkg::OP_ACC || item.op == bmst_pkg::OP_READ);
		ctl.upd_en = (st_q == bmst_pkg::ST_ACC);
		ctl.clr    = accept && (item.op == bmst_pkg::OP_CLEAR);
	end

	// row and hit held for the update and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= item.row;
			hit_q <= in_range;
		end
	end

	// lanes: each keeps one chunk value and gates it by its pattern bit
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic sel;
		// upper lanes only take part in eight-column mode
		assign sel = item.pattern[k] && ((k < bmst_pkg::GROUP_SMALL) || group_mode_q);

		bmst_lane #(
			.VALUE_BITS (VALUE_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.load_en   (accept && item.op == bmst_pkg::OP_LOAD),
			.x_in      (x_field[k]),
			.acc_en    (accept && item.op == bmst_pkg::OP_ACC),
			.sel       (sel),
			.masked_s1 (lane_s1[k])
		);
	end

	// merge the lanes into the subset-table entry
	bmst_merge #(
		.LANES      (LANES),
		.VALUE_BITS (VALUE_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_merge (
		.clk     (clk),
		.en      (st_q == bmst_pkg::ST_SUM),
		.lane_s1 (lane_s1),
		.sum_s2  (sum_s2)
	);

	// accumulator store, read on accept and written back at the end
	bmst_rowacc #(
		.ROW_DEPTH (ROW_DEPTH),
		.ADDR_BITS (ADDR_BITS),
		.ACC_BITS  (ACC_BITS),
		.SUM_BITS  (SUM_BITS)
	) u_rowacc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (item.row[ADDR_BITS-1:0]),
		.wr_addr (row_q[ADDR_BITS-1:0]),
		.sum     (sum_s2),
		.rd_acc  (rd_acc),
		.rd_flag (rd_flag)
	);

	// output register, frees the input side while a result word waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.out_row    <= row_q;
			// a row beyond the store reports zero and no overflow
			result_q.row_sum    <= hit_q ? bmst_pkg::SUM_OUT_BITS'(rd_acc) : '0;
			result_q.overflowed <= hit_q & rd_flag;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_sum_then_acc : assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == bmst_pkg::ST_SUM) |=> (st_q == bmst_pkg::ST_ACC))
		else $error("merge stage not followed by row update");

	a_read_enters_wait : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.op == bmst_pkg::OP_READ) |=> (st_q == bmst_pkg::ST_READ))
		else $error("read word did not reach result stage");

	a_result_row : assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == bmst_pkg::ST_READ && out_free) |=>
			(result_valid_q && result_q.out_row == $past(row_q)))
		else $error("result word missing or carries wrong row");

	a_drop_out_of_range : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.op == bmst_pkg::OP_ACC && !in_range) |=>
			(st_q == bmst_pkg::ST_IDLE))
		else $error("accumulate on absent row was not dropped");

endmodule

// ===== verif/binary_matvec_subset_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_matvec_subset_table_test
// self-checking bench for the subset-sum binary matrix-vector block
// ----------------------------------------------------------------------------
// a short list of directed words, with hand-worked row sums for the easy
// cases, is followed by random phases in both group widths. every accepted
// word updates a behavioural model of the chunk values, row accumulators and
// sticky overflow flags; other read results are compared with that model.
// both handshakes idle at random, with one calm phase, one long receiver
// hold-off and a drain before each register write.
// ----------------------------------------------------------------------------
module binary_matvec_subset_table_test;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT      = 38;
	localparam int HOLD_CYCLES   = 300;
	localparam int BURST_READS   = 24;
	localparam int PHASES        = 6;
	localparam int PHASE_WORDS   = 238;

	// group_mode settings
	localparam logic MODE_FOUR  = 1'b0;
	localparam logic MODE_EIGHT = 1'b1;

	localparam longint VAL_HI = (longint'(1) << (bmst_pkg::VALUE_BITS_DEF - 1)) - 1;
	localparam longint VAL_LO = -VAL_HI - 1;
	localparam longint ACC_HI = (longint'(1) << (bmst_pkg::ACC_BITS_DEF - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;

	localparam logic signed [bmst_pkg::FIELD_BITS-1:0] X_MAX =
		{1'b0, {(bmst_pkg::FIELD_BITS-1){1'b1}}};
	localparam logic signed [bmst_pkg::FIELD_BITS-1:0] X_MIN =
		{1'b1, {(bmst_pkg::FIELD_BITS-1){1'b0}}};

	// kinds of row in the directed list
	typedef enum logic [1:0] {
		STEP_PLAIN,
		STEP_TYPED,
		STEP_MODE
	} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		bmst_pkg::bmst_in_t  w;
		bmst_pkg::bmst_out_t want;
		logic                mode;
	} step_t;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	bmst_pkg::bmst_in_t  item;
	logic                result_valid;
	logic                result_ready;
	bmst_pkg::bmst_out_t result;
	logic                cfg_wen;
	logic                cfg_wdata;

	// model of the block's state
	longint lane_val [bmst_pkg::MAX_LANES];
	longint row_acc [bmst_pkg::ROWS_DEF];
	bit     row_sat [bmst_pkg::ROWS_DEF];
	logic   wide_groups;

	// row sums still owed by the block, oldest first
	bmst_pkg::bmst_out_t sum_expect [$];
	step_t               plan [$];

	int errors        = 0;
	int reads_checked = 0;
	int words_sent    = 0;
	int mode_writes   = 0;
	int cycles        = 0;
	bit calm          = 1'b0;
	bit hold_request  = 1'b0;

	binary_matvec_subset_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// apply one accepted word to the model; returns 1 when a row sum is owed
	function automatic bit predict_word(input bmst_pkg::bmst_in_t w,
		output bmst_pkg::bmst_out_t r);
		logic signed [bmst_pkg::FIELD_BITS-1:0] lanes [bmst_pkg::MAX_LANES];
		longint v;
		longint total;
		int     used;
		bit     produced;
		lanes = '{w.x0, w.x1, w.x2, w.x3, w.x4, w.x5, w.x6, w.x7};
		r = '0;
		produced = 1'b0;
		case (w.op)
			bmst_pkg::OP_LOAD: begin
				// all lanes are stored whatever the group width
				for (int k = 0; k < bmst_pkg::LANES_DEF; k++) begin
					v = longint'(lanes[k]);
					lane_val[k] = (v > VAL_HI) ? VAL_HI : ((v < VAL_LO) ? VAL_LO : v);
				end
			end
			bmst_pkg::OP_ACC: begin
				if (w.row < bmst_pkg::ROWS_DEF) begin
					// four-column mode looks at pattern bits 0..3 only
					used = (wide_groups == MODE_EIGHT) ? bmst_pkg::LANES_DEF
						: bmst_pkg::GROUP_SMALL;
					total = 0;
					for (int k = 0; k < used; k++)
						if (w.pattern[k])
							total += lane_val[k];
					total += row_acc[w.row];
					// clip past the bounds; landing on a bound leaves the flag alone
					if (total > ACC_HI) begin
						row_acc[w.row] = ACC_HI;
						row_sat[w.row] = 1'b1;
					end else if (total < ACC_LO) begin
						row_acc[w.row] = ACC_LO;
						row_sat[w.row] = 1'b1;
					end else begin
						row_acc[w.row] = total;
					end
				end
			end
			bmst_pkg::OP_READ: begin
				r.out_row = w.row;
				if (w.row < bmst_pkg::ROWS_DEF) begin
					r.row_sum    = row_acc[w.row][bmst_pkg::SUM_OUT_BITS-1:0];
					r.overflowed = row_sat[w.row];
				end
				produced = 1'b1;
			end
			default: begin
				for (int k = 0; k < bmst_pkg::ROWS_DEF; k++) begin
					row_acc[k] = 0;
					row_sat[k] = 1'b0;
				end
			end
		endcase
		return produced;
	endfunction

	function automatic bmst_pkg::bmst_in_t mk_load(
		input logic signed [bmst_pkg::FIELD_BITS-1:0] v0, v1, v2, v3, v4, v5, v6, v7
	);
		bmst_pkg::bmst_in_t w;
		w = '0;
		w.op = bmst_pkg::OP_LOAD;
		w.x0 = v0; w.x1 = v1; w.x2 = v2; w.x3 = v3;
		w.x4 = v4; w.x5 = v5; w.x6 = v6; w.x7 = v7;
		return w;
	endfunction

	function automatic bmst_pkg::bmst_in_t mk_op(input bmst_pkg::bmst_op_t op,
		input int row, input logic [bmst_pkg::PATTERN_BITS-1:0] pat);
		bmst_pkg::bmst_in_t w;
		w = '0;
		w.op = op;
		w.row = bmst_pkg::ROW_BITS'(row);
		w.pattern = pat;
		return w;
	endfunction

	function automatic void add_word(input bmst_pkg::bmst_in_t w);
		step_t s;
		s.kind = STEP_PLAIN;
		s.w = w;
		s.want = '0;
		s.mode = 1'b0;
		plan = {plan, s};
	endfunction

	// read word whose sum is worked out by hand, flag clear
	function automatic void add_checked(input int row, input longint sum);
		step_t s;
		s.kind = STEP_TYPED;
		s.w = mk_op(bmst_pkg::OP_READ, row, '0);
		s.want.out_row = bmst_pkg::ROW_BITS'(row);
		s.want.row_sum = bmst_pkg::SUM_OUT_BITS'(sum);
		s.want.overflowed = 1'b0;
		s.mode = 1'b0;
		plan = {plan, s};
	endfunction

	function automatic void add_mode(input logic m);
		step_t s;
		s.kind = STEP_MODE;
		s.w = '0;
		s.want = '0;
		s.mode = m;
		plan = {plan, s};
	endfunction

	// extremes now and then, otherwise any 24-bit pattern
	function automatic logic signed [bmst_pkg::FIELD_BITS-1:0] rand_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return X_MAX;
		if (pick < 30)
			return X_MIN;
		return bmst_pkg::FIELD_BITS'($urandom);
	endfunction

	// mostly accumulates with some loads, a good share of reads,
	// and a rare clear; unused fields carry random noise
	function automatic bmst_pkg::bmst_in_t rand_word(input bit read_only);
		bmst_pkg::bmst_in_t w;
		int pick;
		pick = read_only ? 70 : $urandom_range(99);
		if (pick < 12)
			w.op = bmst_pkg::OP_LOAD;
		else if (pick < 62)
			w.op = bmst_pkg::OP_ACC;
		else if (pick < 96)
			w.op = bmst_pkg::OP_READ;
		else
			w.op = bmst_pkg::OP_CLEAR;
		// a few hot rows so sums build up, the rest spread over all rows
		w.row = ($urandom_range(99) < 50) ? bmst_pkg::ROW_BITS'($urandom_range(3))
			: bmst_pkg::ROW_BITS'($urandom_range(bmst_pkg::ROW_SPACE - 1));
		pick = $urandom_range(99);
		if (pick < 10)
			w.pattern = '0;
		else if (pick < 20)
			w.pattern = '1;
		else
			w.pattern = bmst_pkg::PATTERN_BITS'($urandom);
		w.x0 = rand_value(); w.x1 = rand_value(); w.x2 = rand_value();
		w.x3 = rand_value(); w.x4 = rand_value(); w.x5 = rand_value();
		w.x6 = rand_value(); w.x7 = rand_value();
		return w;
	endfunction

	// offer one word from a falling edge and hold it until taken;
	// returns at the falling edge after acceptance
	task automatic send_word(input bmst_pkg::bmst_in_t w, input bit typed,
		input bmst_pkg::bmst_out_t want);
		bmst_pkg::bmst_out_t r;
		item <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		words_sent++;
		if (predict_word(w, r)) begin
			if (typed)
				r = want;
			sum_expect = {sum_expect, r};
		end
		@(negedge clk);
	endtask

	// stop offering, wait for every owed sum, then let a trailing
	// accumulate finish its row update
	task automatic drain();
		item_valid <= 1'b0;
		while (sum_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// register writes only while the block is quiet
	task automatic write_mode(input logic m);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_wen <= 1'b0;
		wide_groups = m;
		mode_writes++;
	endtask

	// sender
	initial begin
		bmst_pkg::bmst_out_t none;
		int                  burst;
		none = '0;
		burst = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_wen = 1'b0;
		cfg_wdata = 1'b0;
		wide_groups = MODE_EIGHT;
		for (int k = 0; k < bmst_pkg::MAX_LANES; k++)
			lane_val[k] = 0;
		for (int k = 0; k < bmst_pkg::ROWS_DEF; k++) begin
			row_acc[k] = 0;
			row_sat[k] = 1'b0;
		end

		// directed list: reset state, full-scale lanes, pattern extremes,
		// four-column mode ignoring the upper pattern bits, clear
		add_mode(MODE_EIGHT);
		add_checked(0, 0);
		add_checked(bmst_pkg::ROW_SPACE - 1, 0);
		add_word(mk_load(X_MAX, X_MAX, X_MAX, X_MAX, X_MAX, X_MAX, X_MAX, X_MAX));
		add_word(mk_op(bmst_pkg::OP_ACC, 0, 8'hFF));
		add_checked(0, 8 * VAL_HI);
		add_word(mk_load(X_MIN, X_MIN, X_MIN, X_MIN, X_MIN, X_MIN, X_MIN, X_MIN));
		add_word(mk_op(bmst_pkg::OP_ACC, bmst_pkg::ROW_SPACE - 1, 8'hFF));
		add_checked(bmst_pkg::ROW_SPACE - 1, 8 * VAL_LO);
		add_word(mk_op(bmst_pkg::OP_ACC, 0, 8'h00));
		add_checked(0, 8 * VAL_HI);
		add_word(mk_load(24'sh000001, X_MAX, X_MIN, -24'sd1,
			24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 24'shF0F0F0));
		add_word(mk_op(bmst_pkg::OP_ACC, 7, 8'h55));
		add_word(mk_op(bmst_pkg::OP_ACC, 7, 8'hAA));
		add_word(mk_op(bmst_pkg::OP_ACC, 7, 8'h80));
		add_word(mk_op(bmst_pkg::OP_READ, 7, 8'h00));
		add_word(mk_op(bmst_pkg::OP_CLEAR, 0, 8'h00));
		add_checked(0, 0);
		add_checked(7, 0);
		add_mode(MODE_FOUR);
		add_word(mk_load(X_MAX, X_MAX, X_MAX, X_MAX, X_MAX, X_MAX, X_MAX, X_MAX));
		add_word(mk_op(bmst_pkg::OP_ACC, 2, 8'hF0));
		add_checked(2, 0);
		add_word(mk_op(bmst_pkg::OP_ACC, 3, 8'hFF));
		add_checked(3, 4 * VAL_HI);
		add_word(mk_op(bmst_pkg::OP_ACC, 4, 8'h3C));
		add_word(mk_op(bmst_pkg::OP_READ, 4, 8'h00));

		// reset held, then released at a falling edge
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				STEP_MODE:  write_mode(plan[i].mode);
				STEP_TYPED: send_word(plan[i].w, 1'b1, plan[i].want);
				default:    send_word(plan[i].w, 1'b0, none);
			endcase
		end

		// random phases alternate the group width; phase four runs calm
		for (int p = 0; p < PHASES; p++) begin
			write_mode((p % 2 == 0) ? MODE_EIGHT : MODE_FOUR);
			calm = (p == 4);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// long receiver hold-off with a run of reads pressed against it
				if (p == 2 && n == 100) begin
					hold_request = 1'b1;
					burst = BURST_READS;
				end
				if (!calm && burst == 0 && $urandom_range(99) < IDLE_PCT) begin
					item_valid <= 1'b0;
					repeat ($urandom_range(3, 1))
						@(negedge clk);
				end
				send_word(rand_word(burst != 0), 1'b0, none);
				if (burst != 0)
					burst--;
			end
		end
		calm = 1'b0;
		drain();

		$display("%0d words in %0d register settings, %0d row sums compared",
			words_sent, mode_writes, reads_checked);
		$display("loads, accumulates in both widths, reads under back-pressure, clears");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// receiver: random ready, a calm phase, and one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (calm) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// result checker: each taken word against the oldest owed sum
	always @(posedge clk) begin
		bmst_pkg::bmst_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (sum_expect.size() == 0) begin
				errors++;
				$display("%0t: result with none owed: row %0d sum %0d flag %0b",
					$time, result.out_row, result.row_sum, result.overflowed);
			end else begin
				want = sum_expect.pop_front();
				reads_checked++;
				if (result !== want) begin
					errors++;
					$display("%0t: expected row %0d sum %0d flag %0b, got row %0d sum %0d flag %0b",
						$time, want.out_row, want.row_sum, want.overflowed,
						result.out_row, result.row_sum, result.overflowed);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: stopped after %0d cycles, %0d sums still owed",
				$time, cycles, sum_expect.size());
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
